>>> hdl/line_command_field_extractor_top_macros.svh
// ----------------------------------------------------------------------------
// line command field extractor assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_COMMAND_FIELD_EXTRACTOR_TOP_MACROS_SVH
`define LINE_COMMAND_FIELD_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication
`define LCFE_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("lcfe assertion failed");

// next-cycle implication
`define LCFE_ASSERT_NXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("lcfe assertion failed");

`endif

>>> hdl/lcfe_pkg.sv
// ----------------------------------------------------------------------------
// lcfe_pkg
// types, constants and key tables of the line command field extractor
// ----------------------------------------------------------------------------
package lcfe_pkg;

  localparam int LINE_BYTES  = 256;
  localparam int BC_W        = $clog2(LINE_BYTES);
  localparam int NUM_KEYS    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  localparam logic [127:0] KEY_TEXT_SEQ   = {"seq", 104'd0};
  localparam logic [127:0] KEY_TEXT_LEFT  = {"left", "_speed", 48'd0};
  localparam logic [127:0] KEY_TEXT_RIGHT = {"right", "_speed", 40'd0};
  localparam logic [127:0] KEY_TEXT_ANGLE = {"servo", "_angle", 40'd0};

  typedef enum logic [1:0] {
    KEY_SEQ,
    KEY_LEFT,
    KEY_RIGHT,
    KEY_ANGLE
  } key_id_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_PUNCT,
    PH_WS,
    PH_SIGNED,
    PH_DIGITS,
    PH_GOOD,
    PH_BAD
  } phase_t;

  typedef struct packed {
    logic kind;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic status;
    logic signed [31:0] seq_value;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;
    logic signed [31:0] angle_value;
    logic [31:0] lines_accepted;
  } out_word_t;

  typedef struct packed {
    logic is_digit;
    logic [3:0] digit;
    logic is_sign;
    logic is_minus;
    logic is_punct;
    logic is_cspace;
    logic is_newline;
    logic is_nul;
  } byte_class_t;

  typedef struct packed {
    logic kind;
    logic [7:0] rx_byte;
    byte_class_t cls;
  } q_entry_t;

  typedef struct packed {
    logic ok;
    logic neg;
    logic [31:0] acc;
  } key_field_t;

  function automatic logic [3:0] key_len(key_id_t k);
    logic [3:0] len;
    begin
      unique case (k)
        KEY_SEQ:   len = 4'd3;
        KEY_LEFT:  len = 4'd10;
        KEY_RIGHT: len = 4'd11;
        KEY_ANGLE: len = 4'd11;
        default:   len = 4'd11;
      endcase
      return len;
    end
  endfunction

  function automatic logic [7:0] key_char(key_id_t k, logic [3:0] p);
    logic [127:0] t;
    begin
      unique case (k)
        KEY_SEQ:   t = KEY_TEXT_SEQ;
        KEY_LEFT:  t = KEY_TEXT_LEFT;
        KEY_RIGHT: t = KEY_TEXT_RIGHT;
        KEY_ANGLE: t = KEY_TEXT_ANGLE;
        default:   t = KEY_TEXT_SEQ;
      endcase
      return t[{~p, 3'b000} +: 8];
    end
  endfunction

endpackage

>>> hdl/lcfe_front.sv
// ----------------------------------------------------------------------------
// lcfe_front
// accepts input words, classifies the byte and queues them for the back end
// ----------------------------------------------------------------------------
`include "line_command_field_extractor_top_macros.svh"

module lcfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcfe_pkg::in_word_t in_word,
  output logic              q_valid,
  output lcfe_pkg::q_entry_t q_entry,
  input  logic              q_pop
);
  import lcfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t    mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic        push;
  byte_class_t cls;
  logic [7:0]  c;

  // byte classification
  always_comb begin
    c = in_word.rx_byte;
    cls.is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    cls.digit      = c[3:0];
    cls.is_sign    = (c == CH_PLUS) || (c == CH_MINUS);
    cls.is_minus   = (c == CH_MINUS);
    cls.is_punct   = (c == CH_QUOTE) || (c == CH_COLON) || (c == CH_SPACE) || (c == CH_TAB);
    cls.is_cspace  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    cls.is_newline = (c == CH_NEWLINE);
    cls.is_nul     = (c == CH_NUL);
  end

  assign in_stall = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{kind: in_word.kind, rx_byte: in_word.rx_byte, cls: cls};
    end
  end

  `LCFE_ASSERT_IMP(a_pop_nonempty, q_pop, count_r != '0)
  `LCFE_ASSERT_NXT(a_count_push, push && !q_pop, count_r == $past(count_r) + 1'b1)

endmodule

>>> hdl/lcfe_key.sv
// ----------------------------------------------------------------------------
// lcfe_key
// one key matcher: finds the key, skips separators, accumulates the number
// ----------------------------------------------------------------------------
module lcfe_key (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcfe_pkg::key_id_t    key_sel,
  input  logic                 step,
  input  logic                 clear,
  input  lcfe_pkg::byte_class_t cls,
  input  logic [7:0]           rx_byte,
  output lcfe_pkg::key_field_t field
);
  import lcfe_pkg::*;

  localparam logic [31:0] MAG_LIMIT      = 32'h8000_0000;
  localparam logic [31:0] DIGIT_THR      = 32'd214748364;
  localparam logic [31:0] DIGIT_THR_NINE = 32'd214748363;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [3:0]  len;
  logic [7:0]  ch_at;
  logic [7:0]  ch_first;
  logic        hit;
  logic [3:0]  pos_inc;
  logic [31:0] acc_add;
  logic        starting;

  function automatic logic [31:0] add_digit(logic [31:0] a, logic [3:0] d);
    logic [31:0] thr;
    begin
      thr = (d == 4'd9) ? DIGIT_THR_NINE : DIGIT_THR;
      if (a > thr) begin
        return MAG_LIMIT;
      end
      return {a[28:0], 3'b000} + {a[30:0], 1'b0} + {28'd0, d};
    end
  endfunction

  function automatic phase_t start_phase(byte_class_t b);
    begin
      if (b.is_sign) begin
        return PH_SIGNED;
      end else if (b.is_digit) begin
        return PH_DIGITS;
      end
      return PH_BAD;
    end
  endfunction

  assign len      = key_len(key_sel);
  assign ch_at    = key_char(key_sel, pos_r);
  assign ch_first = key_char(key_sel, 4'd0);
  assign hit      = (pos_r < len) && (ch_at == rx_byte);
  assign pos_inc  = hit ? pos_r + 4'd1 : ((ch_first == rx_byte) ? 4'd1 : 4'd0);
  assign acc_add  = add_digit(acc_r, cls.digit);
  assign starting = ((phase_r == PH_PUNCT) && !cls.is_punct && !cls.is_cspace) ||
                    ((phase_r == PH_WS) && !cls.is_cspace);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      unique case (phase_r)
        PH_SEARCH: if (pos_inc >= len) phase_nxt = PH_PUNCT;
        PH_PUNCT: begin
          if (cls.is_punct) begin
            phase_nxt = PH_PUNCT;
          end else if (cls.is_cspace) begin
            phase_nxt = PH_WS;
          end else begin
            phase_nxt = start_phase(cls);
          end
        end
        PH_WS:     if (!cls.is_cspace) phase_nxt = start_phase(cls);
        PH_SIGNED: phase_nxt = cls.is_digit ? PH_DIGITS : PH_BAD;
        PH_DIGITS: if (!cls.is_digit) phase_nxt = PH_GOOD;
        PH_GOOD:   phase_nxt = PH_GOOD;
        PH_BAD:    phase_nxt = PH_BAD;
        default:   phase_nxt = PH_BAD;
      endcase
    end
  end

  // match position, sign and accumulator
  always_comb begin
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    if (step) begin
      unique case (phase_r) inside
        PH_SEARCH: pos_nxt = (pos_inc >= len) ? 4'd0 : pos_inc;
        PH_PUNCT, PH_WS: begin
          if (starting) begin
            if (cls.is_sign) begin
              neg_nxt = cls.is_minus;
            end else if (cls.is_digit) begin
              acc_nxt = acc_add;
            end
          end
        end
        PH_SIGNED, PH_DIGITS: if (cls.is_digit) acc_nxt = acc_add;
        PH_GOOD, PH_BAD: begin
          acc_nxt = acc_r;
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  assign field = '{ok: (phase_nxt == PH_DIGITS) || (phase_nxt == PH_GOOD),
                   neg: neg_nxt, acc: acc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_SEARCH;
      pos_r   <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

>>> hdl/lcfe_back.sv
// ----------------------------------------------------------------------------
// lcfe_back
// line framing, idle timeout, four key matchers and the result register
// ----------------------------------------------------------------------------
`include "line_command_field_extractor_top_macros.svh"

module lcfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lcfe_pkg::q_entry_t q_entry,
  output logic               q_pop,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lcfe_pkg::out_word_t out_word
);
  import lcfe_pkg::*;

  logic [31:0]     timeout_r, timeout_nxt;
  logic [31:0]     idle_r, idle_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt;
  logic            nul_seen_r, nul_seen_nxt;
  logic            line_empty_r, line_empty_nxt;
  logic [31:0]     cmd_cnt_r, cmd_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            status_r;
  logic [31:0]     out_cnt_r;
  key_field_t      out_fld_r [NUM_KEYS];

  key_field_t      fld [NUM_KEYS];
  logic            go;
  logic            is_idle;
  logic [31:0]     idle_inc;
  logic [BC_W-1:0] bc_inc;
  logic            nul_new;
  logic            empty_new;
  logic            step;
  logic            finish;
  logic            nocmd;
  logic [31:0]     cmd_inc;

  function automatic logic [31:0] field_val(key_field_t f, logic [31:0] dflt);
    begin
      if (!f.ok) begin
        return dflt;
      end else if (f.neg) begin
        return 32'd0 - f.acc;
      end
      return f.acc[31] ? 32'h7FFF_FFFF : f.acc;
    end
  endfunction

  assign go        = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = go;
  assign is_idle   = q_entry.kind;
  assign idle_inc  = idle_r + 32'd1;
  assign bc_inc    = bc_r + 1'b1;
  assign nul_new   = nul_seen_r || q_entry.cls.is_nul;
  assign empty_new = line_empty_r || (q_entry.cls.is_nul && (bc_r == '0));
  assign step      = go && !is_idle && !nul_new;
  assign cmd_inc   = cmd_cnt_r + 32'd1;

  always_comb begin
    if (is_idle) begin
      finish = (idle_inc >= timeout_r);
      nocmd  = (bc_r == '0) || line_empty_r;
    end else begin
      finish = q_entry.cls.is_newline || (bc_inc == BC_W'(LINE_BYTES - 1));
      nocmd  = empty_new;
    end
  end

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    lcfe_key u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .key_sel (key_id_t'(i)),
      .step    (step),
      .clear   (go && finish),
      .cls     (q_entry.cls),
      .rx_byte (q_entry.rx_byte),
      .field   (fld[i])
    );
  end

  always_comb begin
    timeout_nxt    = cfg_write ? cfg_data : timeout_r;
    idle_nxt       = idle_r;
    bc_nxt         = bc_r;
    nul_seen_nxt   = nul_seen_r;
    line_empty_nxt = line_empty_r;
    cmd_cnt_nxt    = cmd_cnt_r;
    out_valid_nxt  = out_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = go && finish;
    end
    if (go) begin
      if (finish) begin
        idle_nxt       = '0;
        bc_nxt         = '0;
        nul_seen_nxt   = 1'b0;
        line_empty_nxt = 1'b0;
        if (!nocmd) begin
          cmd_cnt_nxt = cmd_inc;
        end
      end else if (is_idle) begin
        idle_nxt = idle_inc;
      end else begin
        idle_nxt       = '0;
        bc_nxt         = bc_inc;
        nul_seen_nxt   = nul_new;
        line_empty_nxt = empty_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RESET;
      idle_r       <= '0;
      bc_r         <= '0;
      nul_seen_r   <= 1'b0;
      line_empty_r <= 1'b0;
      cmd_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      timeout_r    <= timeout_nxt;
      idle_r       <= idle_nxt;
      bc_r         <= bc_nxt;
      nul_seen_r   <= nul_seen_nxt;
      line_empty_r <= line_empty_nxt;
      cmd_cnt_r    <= cmd_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload, no-command results carry zeros
  always_ff @(posedge clk) begin
    if (go && finish) begin
      status_r  <= nocmd;
      out_cnt_r <= nocmd ? 32'd0 : cmd_inc;
      for (int k = 0; k < NUM_KEYS; k++) begin
        out_fld_r[k] <= nocmd ? '0 : fld[k];
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_word.status         = status_r;
    out_word.seq_value      = field_val(out_fld_r[KEY_SEQ], out_cnt_r);
    out_word.left_value     = field_val(out_fld_r[KEY_LEFT], 32'd0);
    out_word.right_value    = field_val(out_fld_r[KEY_RIGHT], 32'd0);
    out_word.angle_value    = field_val(out_fld_r[KEY_ANGLE], 32'd0);
    out_word.lines_accepted = out_cnt_r;
  end

  `LCFE_ASSERT_NXT(a_cmd_count, go && finish && !nocmd, cmd_cnt_r == $past(cmd_cnt_r) + 32'd1)
  `LCFE_ASSERT_NXT(a_line_clear, go && finish, (bc_r == '0) && (idle_r == '0))

endmodule

>>> hdl/line_command_field_extractor_top.sv
// ----------------------------------------------------------------------------
// line_command_field_extractor_top
// frames received bytes and idle ticks into lines and extracts four fields
// ----------------------------------------------------------------------------
//   channel   dir  handshake          word
//   in_       in   in_valid/in_stall  in_word  (kind, rx_byte)
//   out_      out  out_valid/out_stall out_word (status, fields, line count)
//   cfg_      in   cfg_valid/cfg_ready cfg_data (timeout_limit)
//
// one word per cycle sustained while out_stall is low; the result register
// loads after acceptance via front queue write, then back end update
// the two-entry front queue lets input be taken while a result waits
// out_valid comes from a register and never depends on out_stall
// reset is synchronous on rst_n; no clearing pass, ready the next cycle
// cfg_ready is always high; write only while the block is idle
// ----------------------------------------------------------------------------
module line_command_field_extractor_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcfe_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lcfe_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import lcfe_pkg::*;

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  assign cfg_ready = 1'b1;

  lcfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  lcfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
